// File: hdl/asba_pkg.sv
// ----------------------------------------------------------------------------
// asba_pkg
// Shared types and constants of the ASID bitmap allocator: map word type,
// command codes, sequencer states and reserved identifiers.
// ----------------------------------------------------------------------------
package asba_pkg;

  // bitmap word geometry
  localparam int WORD_BITS    = 64;
  localparam int BIT_IDX_BITS = 6;
  localparam int ASID_W       = 8;
  localparam int MAX_ID_BITS  = 16;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ASID_W-1:0]    asid_t;

  // reserved identifiers and reset contents of word zero
  localparam asid_t SHARED_ID   = 8'd1;
  localparam asid_t NONE_ID     = 8'd0;
  localparam word_t RESET_WORD0 = 64'd3;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_MOD,
    S_SCAN,
    S_FREE_MOD
  } state_t;

endpackage

// File: hdl/asid_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// asid_bitmap_allocator
// Address-space identifier allocator: in-use bitmap in a word memory plus a
// first-free pointer, with a read-modify-write sequencer and word scan.
// ----------------------------------------------------------------------------
// Sequence: an allocate reads the word at the first-free pointer, sets its bit
//   and scans on to a word with a clear bit or the last (1 to 2**(ID_BITS-6) words
//   read); a valid free clears its bit; other requests read no word.
// Throughput: one transaction at a time, limited by the single memory read port;
//   the next start is taken in the cycle the result strobe is shown.
// Reset: a clearing pass writes all 2**(ID_BITS-6) map words (4 at default)
//   with busy high. Results are strobed once and the receiver cannot stall.
module asid_bitmap_allocator #(
  parameter int ID_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic command,
  input  asba_pkg::asid_t asid_in,
  output logic done,
  output asba_pkg::asid_t asid_out,
  output logic invalidate_request
);
  import asba_pkg::*;

  localparam int N_IDS     = 1 << ID_BITS;
  localparam int WADDR     = ID_BITS - BIT_IDX_BITS;
  localparam int MAP_WORDS = 1 << WADDR;

  localparam logic [WADDR-1:0] LAST_WORD = WADDR'(MAP_WORDS - 1);
  localparam logic [ID_BITS:0] FULL_PTR  = (ID_BITS+1)'(N_IDS);

  // lowest clear bit of a map word
  function automatic logic [BIT_IDX_BITS-1:0] lowest_clear(input word_t w);
    logic [BIT_IDX_BITS-1:0] r;
    r = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!w[b]) begin
        r = BIT_IDX_BITS'(b);
      end
    end
    return r;
  endfunction

  state_t state, state_next;

  logic [ID_BITS:0]   first_free, first_free_next;
  logic [ID_BITS-1:0] op_id, op_id_next;
  logic [WADDR-1:0]   scan_addr, scan_addr_next;
  logic [WADDR-1:0]   clr_cnt, clr_cnt_next;

  logic             rd_en, wr_en;
  logic [WADDR-1:0] rd_addr, wr_addr;
  word_t            rd_data, wr_data;

  logic  res_valid, res_inv;
  asid_t res_asid;

  // command decode
  logic                    full, free_ok, is_free;
  logic [31:0]             id_wide;
  logic [ID_BITS-1:0]      id_trunc;
  logic [MAX_ID_BITS-1:0]  op_wide;

  assign is_free  = (cmd_t'(command) == CMD_FREE);
  assign full     = first_free[ID_BITS];
  assign id_wide  = 32'(asid_in);
  assign id_trunc = id_wide[ID_BITS-1:0];
  assign free_ok  = (asid_in != NONE_ID) && (asid_in != SHARED_ID) &&
                    (id_wide < 32'(N_IDS));
  assign op_wide  = MAX_ID_BITS'(op_id);

  // word under check: the just-modified word or a scanned word
  word_t                   set_word, clr_word, chk_word;
  logic [WADDR-1:0]        op_addr, chk_addr;
  logic [BIT_IDX_BITS-1:0] lc;
  logic                    word_full, last;

  assign op_addr   = op_id[ID_BITS-1:BIT_IDX_BITS];
  assign set_word  = rd_data | (word_t'(1) << op_id[BIT_IDX_BITS-1:0]);
  assign clr_word  = rd_data & ~(word_t'(1) << op_id[BIT_IDX_BITS-1:0]);
  assign chk_word  = (state == S_ALLOC_MOD) ? set_word : rd_data;
  assign chk_addr  = (state == S_ALLOC_MOD) ? op_addr : scan_addr;
  assign lc        = lowest_clear(chk_word);
  assign word_full = &chk_word;
  assign last      = (chk_addr == LAST_WORD);

  assign busy = (state != S_IDLE);

  asba_map_ram #(
    .ADDR_BITS (WADDR)
  ) u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (is_free) begin
            state_next = free_ok ? S_FREE_MOD : S_IDLE;
          end else begin
            state_next = full ? S_IDLE : S_ALLOC_MOD;
          end
        end
      end
      S_ALLOC_MOD, S_SCAN: begin
        state_next = (!word_full || last) ? S_IDLE : S_SCAN;
      end
      S_FREE_MOD: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // memory accesses, pointer updates and results
  always_comb begin
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;
    res_valid       = 1'b0;
    res_inv         = 1'b0;
    res_asid        = NONE_ID;
    first_free_next = first_free;
    op_id_next      = op_id;
    scan_addr_next  = scan_addr;
    clr_cnt_next    = clr_cnt;
    case (state)
      S_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_cnt;
        wr_data      = (clr_cnt == '0) ? RESET_WORD0 : '0;
        clr_cnt_next = clr_cnt + WADDR'(1);
      end
      S_IDLE: begin
        if (start) begin
          if (is_free) begin
            if (free_ok) begin
              rd_en      = 1'b1;
              rd_addr    = id_trunc[ID_BITS-1:BIT_IDX_BITS];
              op_id_next = id_trunc;
            end else begin
              res_valid = 1'b1;
            end
          end else if (full) begin
            res_valid = 1'b1;
            res_asid  = SHARED_ID;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = first_free[ID_BITS-1:BIT_IDX_BITS];
            op_id_next = first_free[ID_BITS-1:0];
          end
        end
      end
      S_ALLOC_MOD, S_SCAN: begin
        if (state == S_ALLOC_MOD) begin
          wr_en   = 1'b1;
          wr_addr = op_addr;
          wr_data = set_word;
        end
        if (!word_full || last) begin
          first_free_next = word_full ? FULL_PTR : {1'b0, chk_addr, lc};
          res_valid       = 1'b1;
          res_inv         = 1'b1;
          res_asid        = op_wide[ASID_W-1:0];
        end else begin
          rd_en          = 1'b1;
          rd_addr        = chk_addr + WADDR'(1);
          scan_addr_next = chk_addr + WADDR'(1);
        end
      end
      S_FREE_MOD: begin
        wr_en   = 1'b1;
        wr_addr = op_addr;
        wr_data = clr_word;
        if ({1'b0, op_id} < first_free) begin
          first_free_next = {1'b0, op_id};
        end
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_CLEAR;
      first_free         <= (ID_BITS+1)'(2);
      clr_cnt            <= '0;
      done               <= 1'b0;
      invalidate_request <= 1'b0;
    end else begin
      state              <= state_next;
      first_free         <= first_free_next;
      clr_cnt            <= clr_cnt_next;
      done               <= res_valid;
      invalidate_request <= res_valid & res_inv;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_id     <= op_id_next;
    scan_addr <= scan_addr_next;
    asid_out  <= res_asid;
  end

  // pointer never lands on a reserved id
  a_ptr_not_reserved: assert property (@(posedge clk) disable iff (rst)
    first_free >= (ID_BITS+1)'(2))
    else $error("first-free pointer on reserved id");

  // pointer never passes the id count
  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    first_free <= FULL_PTR)
    else $error("first-free pointer beyond id count");

  // a result only follows an accepted transaction or sequencer work
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result strobe without a transaction");

  // invalidate only comes with a result
  a_inv_with_done: assert property (@(posedge clk) disable iff (rst)
    invalidate_request |-> done)
    else $error("invalidate request without result strobe");

  // no read of a word in the cycle it is written
  a_no_rw_same_word: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en && (rd_addr == wr_addr)))
    else $error("read and write to the same map word");

endmodule

// File: hdl/asba_map_ram.sv
// ----------------------------------------------------------------------------
// asba_map_ram
// In-use bitmap storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module asba_map_ram #(
  parameter int ADDR_BITS = 2
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [ADDR_BITS-1:0]  rd_addr,
  output asba_pkg::word_t       rd_data,
  input  logic                  wr_en,
  input  logic [ADDR_BITS-1:0]  wr_addr,
  input  asba_pkg::word_t       wr_data
);
  import asba_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;

  word_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
